### design/complex_arith_unit_defines.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define CAU_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define CAU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// types, constants and mode codes of the complex arithmetic unit
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int DEF_FRAC_BITS = 16;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_NEG = 3'd4;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    logic               overflow;
    logic               equal;
  } cau_out_t;

  // per-item control word
  typedef struct packed {
    logic [2:0] mode;
    logic       equal;
    logic       div_zero;
  } cau_ctl_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sh0_7fff_ffff) r = {1'b1, SAT_MAX};
    else if (v < -66'sh0_8000_0000) r = {1'b1, SAT_MIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

### design/cau_mul_stage.sv
// ---------------------------------------------------------------------------
// cau_mul_stage
// six registered 32x32 signed products and the three sums of products
// ---------------------------------------------------------------------------
module cau_mul_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  cau_pkg::cau_in_t       in_word,
  output logic                   out_valid,
  output cau_pkg::cau_in_t       out_word,
  output logic signed [65:0]     s_re,
  output logic signed [65:0]     s_im,
  output logic signed [65:0]     den
);
  import cau_pkg::*;

  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic               v1;
  cau_in_t            w1;

  // stage 1: products (b squares reuse the same operands)
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    w1   <= in_word;
    p_rr <= in_word.a_re * in_word.b_re;
    p_ii <= in_word.a_im * in_word.b_im;
    p_ri <= in_word.a_re * in_word.b_im;
    p_ir <= in_word.a_im * in_word.b_re;
    p_bb <= in_word.b_re * in_word.b_re;
    p_cc <= in_word.b_im * in_word.b_im;
  end

  // stage 2: sums; multiply form for mul, conjugate form for div
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    out_word <= w1;
    if (w1.mode == MODE_DIV) begin
      s_re <= 66'(p_rr) + 66'(p_ii);
      s_im <= 66'(p_ir) - 66'(p_ri);
    end else begin
      s_re <= 66'(p_rr) - 66'(p_ii);
      s_im <= 66'(p_ri) + 66'(p_ir);
    end
    den <= 66'(p_bb) + 66'(p_cc);
  end

endmodule

### design/cau_div_pipe.sv
// ---------------------------------------------------------------------------
// cau_div_pipe
// pipelined restoring divider, one quotient bit per stage, with passthrough
// ---------------------------------------------------------------------------
module cau_div_pipe #(
  parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  cau_pkg::cau_in_t       in_word,
  input  logic signed [65:0]     s_re,
  input  logic signed [65:0]     s_im,
  input  logic signed [65:0]     den,
  output logic                   out_valid,
  output cau_pkg::cau_in_t       out_word,
  output logic signed [65:0]     o_re,
  output logic signed [65:0]     o_im,
  output logic [33:0]            q_re,
  output logic [33:0]            q_im,
  output logic                   n_re,
  output logic                   n_im
);
  import cau_pkg::*;

  // dividend = |num| << FRAC_BITS; the 34-bit quotient is clamped to 2^34-1 once it reaches 2^33
  localparam int NW    = 64 + FRAC_BITS;
  localparam int STEPS = 34;
  localparam int DW    = NW + 1;

  logic               v   [STEPS+1];
  cau_in_t            w   [STEPS+1];
  logic signed [65:0] sr  [STEPS+1];
  logic signed [65:0] si  [STEPS+1];
  logic [63:0]        d   [STEPS+1];
  logic [DW-1:0]      rr  [STEPS+1];
  logic [DW-1:0]      ri  [STEPS+1];
  logic [NW-1:0]      nr  [STEPS+1];
  logic [NW-1:0]      ni  [STEPS+1];
  logic [33:0]        qr  [STEPS+1];
  logic [33:0]        qi  [STEPS+1];
  logic               hr  [STEPS+1];
  logic               hi  [STEPS+1];

  logic [64:0] mag_re, mag_im;

  always_comb begin
    mag_re = s_re[65] ? 65'(-s_re) : s_re[64:0];
    mag_im = s_im[65] ? 65'(-s_im) : s_im[64:0];
  end

  // leading quotient bits from 2^33 up only matter as saturation; folded into
  // the high flag by a compare of the shifted dividend
  always_comb begin
    v[0]  = in_valid;
    w[0]  = in_word;
    sr[0] = s_re;
    si[0] = s_im;
    d[0]  = den[63:0];
    nr[0] = NW'(mag_re) << FRAC_BITS;
    ni[0] = NW'(mag_im) << FRAC_BITS;
    rr[0] = '0;
    ri[0] = '0;
    qr[0] = '0;
    qi[0] = '0;
    hr[0] = 1'b0;
    hi[0] = 1'b0;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    // quotient bit position handled by this stage
    localparam int SH = STEPS - 1 - g;
    logic [DW-1:0] tr, ti;
    // partial remainder before this bit: top bits of dividend down to SH
    always_comb begin
      if (g == 0) begin
        tr = DW'(nr[g] >> SH);
        ti = DW'(ni[g] >> SH);
      end else begin
        tr = {rr[g][DW-2:0], nr[g][SH]};
        ti = {ri[g][DW-2:0], ni[g][SH]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else v[g+1] <= v[g];
      w[g+1]  <= w[g];
      sr[g+1] <= sr[g];
      si[g+1] <= si[g];
      d[g+1]  <= d[g];
      nr[g+1] <= nr[g];
      ni[g+1] <= ni[g];
      if (g == 0) begin
        // quotient >= 2^33 when top part already >= den
        hr[g+1] <= tr >= DW'(d[g]);
        hi[g+1] <= ti >= DW'(d[g]);
        rr[g+1] <= (tr >= DW'(d[g])) ? tr - DW'(d[g]) : tr;
        ri[g+1] <= (ti >= DW'(d[g])) ? ti - DW'(d[g]) : ti;
        qr[g+1] <= '0;
        qi[g+1] <= '0;
      end else begin
        hr[g+1] <= hr[g];
        hi[g+1] <= hi[g];
        rr[g+1] <= (tr >= DW'(d[g])) ? tr - DW'(d[g]) : tr;
        ri[g+1] <= (ti >= DW'(d[g])) ? ti - DW'(d[g]) : ti;
        qr[g+1] <= {qr[g][32:0], tr >= DW'(d[g])};
        qi[g+1] <= {qi[g][32:0], ti >= DW'(d[g])};
      end
    end
  end

  always_comb begin
    out_valid = v[STEPS];
    out_word  = w[STEPS];
    o_re      = sr[STEPS];
    o_im      = si[STEPS];
    n_re      = sr[STEPS][65];
    n_im      = si[STEPS][65];
    q_re      = hr[STEPS] ? 34'h3_ffff_ffff : qr[STEPS];
    q_im      = hi[STEPS] ? 34'h3_ffff_ffff : qi[STEPS];
  end

endmodule

### design/cau_result.sv
// ---------------------------------------------------------------------------
// cau_result
// per-mode result selection and saturation, registered
// ---------------------------------------------------------------------------
module cau_result #(
  parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cau_pkg::cau_in_t   in_word,
  input  logic signed [65:0] s_re,
  input  logic signed [65:0] s_im,
  input  logic [33:0]        q_re,
  input  logic [33:0]        q_im,
  input  logic               n_re,
  input  logic               n_im,
  input  logic               dz,
  output logic               out_valid,
  output cau_pkg::cau_out_t  out_word
);
  import cau_pkg::*;

  logic [32:0] sr, si;
  cau_out_t    nx;

  function automatic logic [32:0] sat_q(input logic neg, input logic [33:0] q);
    logic signed [65:0] v;
    v = neg ? -$signed({32'd0, q}) : $signed({32'd0, q});
    return sat66(v);
  endfunction

  always_comb begin
    sr = '0;
    si = '0;
    case (in_word.mode)
      MODE_ADD: begin
        sr = sat66(66'(in_word.a_re) + 66'(in_word.b_re));
        si = sat66(66'(in_word.a_im) + 66'(in_word.b_im));
      end
      MODE_SUB: begin
        sr = sat66(66'(in_word.a_re) - 66'(in_word.b_re));
        si = sat66(66'(in_word.a_im) - 66'(in_word.b_im));
      end
      MODE_MUL: begin
        sr = sat66(s_re >>> FRAC_BITS);
        si = sat66(s_im >>> FRAC_BITS);
      end
      MODE_DIV: begin
        if (!dz) begin
          sr = sat_q(n_re, q_re);
          si = sat_q(n_im, q_im);
        end
      end
      MODE_NEG: begin
        sr = sat66(-66'(in_word.a_re));
        si = sat66(-66'(in_word.a_im));
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    nx.res_re   = sr[31:0];
    nx.res_im   = si[31:0];
    nx.overflow = sr[32] | si[32];
    nx.div_zero = dz;
    nx.equal    = (in_word.a_re == in_word.b_re) && (in_word.a_im == in_word.b_im);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    out_word <= nx;
  end

endmodule

### design/complex_arith_unit.sv
// every mode takes the same path from an accepted start to the done strobe
// throughput: one word per cycle, busy is never raised
// the depth is set by the 34-stage divider, one quotient bit per stage;
// other modes ride along beside it so results leave in order
// reset clears all valid bits; payload registers are not reset
// ---------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add, subtract, multiply, divide and negate on Q16.16
// ---------------------------------------------------------------------------
module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  operands,
  output logic              done,
  output cau_pkg::cau_out_t result
);
  import cau_pkg::*;

  // product stage outputs
  logic               m_valid;
  cau_in_t            m_word;
  logic signed [65:0] m_re, m_im, m_den;

  // divider outputs
  logic               d_valid;
  cau_in_t            d_word;
  logic signed [65:0] d_re, d_im;
  logic [33:0]        d_qre, d_qim;
  logic               d_nre, d_nim;
  logic               d_dz;

  // the pipeline never stalls, so input is always taken
  assign busy = 1'b0;

  cau_mul_stage u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_word  (operands),
    .out_valid(m_valid),
    .out_word (m_word),
    .s_re     (m_re),
    .s_im     (m_im),
    .den      (m_den)
  );

  cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m_valid),
    .in_word  (m_word),
    .s_re     (m_re),
    .s_im     (m_im),
    .den      (m_den),
    .out_valid(d_valid),
    .out_word (d_word),
    .o_re     (d_re),
    .o_im     (d_im),
    .q_re     (d_qre),
    .q_im     (d_qim),
    .n_re     (d_nre),
    .n_im     (d_nim)
  );

  // divide by zero: divide asked and b is zero in both parts
  assign d_dz = (d_word.mode == MODE_DIV) && (d_word.b_re == '0) && (d_word.b_im == '0);

  cau_result #(.FRAC_BITS(FRAC_BITS)) u_res (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_word  (d_word),
    .s_re     (d_re),
    .s_im     (d_im),
    .q_re     (d_qre),
    .q_im     (d_qim),
    .n_re     (d_nre),
    .n_im     (d_nim),
    .dz       (d_dz),
    .out_valid(done),
    .out_word (result)
  );

endmodule

### design/cau_checker.sv
// ---------------------------------------------------------------------------
// cau_checker
// port-level checks of the complex arithmetic unit
// ---------------------------------------------------------------------------
`include "complex_arith_unit_defines.svh"

module cau_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input cau_pkg::cau_in_t  operands,
  input logic              done,
  input cau_pkg::cau_out_t result
);
  import cau_pkg::*;

  `CAU_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy, "busy raised")
  `CAU_ASSERT_IMPL(a_dz_flags, clk, rst, done && result.div_zero, (!result.overflow && result.res_re == '0 && result.res_im == '0), "div by zero result not clean")
  `CAU_ASSERT_IMPL(a_dz_eq, clk, rst, done && result.div_zero && result.equal, (result.res_re == '0), "dz with equal inconsistent")
  `CAU_ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !done, "done right after reset")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .operands(operands),
  .done    (done),
  .result  (result)
);
